/* src/shape_pair_overlap_test_assert.svh */
// Assertion macros shared by the checker of the shape pair overlap test.
// No dependencies; include by bare file name.
`ifndef SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPOT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("shape pair overlap check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPOT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("shape pair overlap check failed");

`endif

/* src/spot_pkg.sv */
// Shared types and constants of the shape pair overlap test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spot_pkg;

    // Default coordinate width, signed positions
    localparam int COORD_BITS_DEF = 16;
    localparam int MODE_BITS      = 2;
    localparam int OUT_BITS       = 8;

    // Shape pair selector
    typedef enum logic [MODE_BITS-1:0] {
        MODE_RECT_RECT = 2'd0,
        MODE_RECT_CIRC = 2'd1,
        MODE_CIRC_RECT = 2'd2,
        MODE_CIRC_CIRC = 2'd3
    } spot_mode_t;

    // Decision flags carried down the pipeline
    typedef struct packed {
        logic pre_hit;  // hit already known without the squared compare
        logic use_sq;   // squared distance compare takes part
    } spot_flags_t;

endpackage

/* src/spot_prep.sv */
// Front stage: selects circle and rectangle, runs the box and side tests
// and forms the differences to be squared. Depends on spot_pkg.
`timescale 1ns / 1ps

module spot_prep
    import spot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [MODE_BITS-1:0]         mode,
    input  logic signed [COORD_BITS-1:0] pos_a_x,
    input  logic signed [COORD_BITS-1:0] pos_a_y,
    input  logic [COORD_BITS-2:0]        dim_a_x,
    input  logic [COORD_BITS-2:0]        dim_a_y,
    input  logic signed [COORD_BITS-1:0] pos_b_x,
    input  logic signed [COORD_BITS-1:0] pos_b_y,
    input  logic [COORD_BITS-2:0]        dim_b_x,
    input  logic [COORD_BITS-2:0]        dim_b_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS+2:0] dx,
    output logic signed [COORD_BITS+2:0] dy,
    output logic [COORD_BITS-1:0]        rsum,
    output spot_flags_t                  flags
);

    localparam int C  = COORD_BITS;
    localparam int D  = COORD_BITS - 1;
    localparam int E  = COORD_BITS + 4;
    localparam int DW = COORD_BITS + 3;

    // Side test on one axis, all values in doubled coordinates
    function automatic logic side_hit(
        input logic signed [E-1:0] c,
        input logic signed [E-1:0] r,
        input logic signed [E-1:0] lo,
        input logic signed [E-1:0] half,
        input logic signed [E-1:0] oc,
        input logic signed [E-1:0] olo,
        input logic signed [E-1:0] ohalf
    );
        logic signed [E-1:0] d;
        logic                reach;
        d = lo + half - c;
        if (!d[E-1])
            reach = (c + r >= lo);
        else
            reach = (c - r < lo + half + half);
        side_hit = reach && (oc <= olo + ohalf + ohalf) && (oc >= olo);
    endfunction

    logic signed [E-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [E-1:0] ra, rb, r;
    logic signed [E-1:0] acx, acy, bcx, bcy, cx, cy;
    logic signed [E-1:0] rx0, ry0, rw0, rh0, lo_x, lo_y;
    logic signed [E-1:0] kx, ky, kx_adj, ky_adj;
    logic signed [E-1:0] rs;
    logic                rr_hit, hit_x, hit_y, circ_is_b;
    spot_mode_t          mode_e;

    logic                valid_reg, valid_next, adv;
    logic signed [DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [C-1:0]        rsum_reg, rsum_next;
    spot_flags_t         flags_reg, flags_next;

    // Extend fields to the working width
    always_comb
    begin
        ax = {{(E-C){pos_a_x[C-1]}}, pos_a_x};
        ay = {{(E-C){pos_a_y[C-1]}}, pos_a_y};
        bx = {{(E-C){pos_b_x[C-1]}}, pos_b_x};
        by = {{(E-C){pos_b_y[C-1]}}, pos_b_y};
        aw = {{(E-D){1'b0}}, dim_a_x};
        ah = {{(E-D){1'b0}}, dim_a_y};
        bw = {{(E-D){1'b0}}, dim_b_x};
        bh = {{(E-D){1'b0}}, dim_b_y};
    end

    // Geometry: radii, doubled centres and the rectangle edges
    always_comb
    begin
        mode_e    = spot_mode_t'(mode);
        circ_is_b = (mode_e == MODE_RECT_CIRC);
        rr_hit    = (ax + aw > bx) && (ax < bx + bw) && (ay < by + bh) && (ay + ah > by);

        ra  = (aw > ah) ? aw : ah;
        rb  = (bw > bh) ? bw : bh;
        acx = ax + ax + ra;
        acy = ay + ay + ra;
        bcx = bx + bx + rb;
        bcy = by + by + rb;
        rs  = ra + rb;

        r   = circ_is_b ? rb  : ra;
        cx  = circ_is_b ? bcx : acx;
        cy  = circ_is_b ? bcy : acy;
        rx0 = circ_is_b ? ax  : bx;
        ry0 = circ_is_b ? ay  : by;
        rw0 = circ_is_b ? aw  : bw;
        rh0 = circ_is_b ? ah  : bh;

        lo_x = rx0 + rx0;
        lo_y = ry0 + ry0;

        hit_x = side_hit(cx, r, lo_x, rw0, cy, lo_y, rh0);
        hit_y = side_hit(cy, r, lo_y, rh0, cx, lo_x, rw0);

        // Offset from the centre to the nearest corner
        kx     = lo_x + rw0 - cx;
        ky     = lo_y + rh0 - cy;
        kx_adj = kx[E-1] ? kx + rw0 : kx - rw0;
        ky_adj = ky[E-1] ? ky + rh0 : ky - rh0;
    end

    // Pick what the later stages see for each shape pair
    always_comb
    begin
        case (mode_e)
            MODE_RECT_RECT:
            begin
                flags_next = '{pre_hit: rr_hit, use_sq: 1'b0};
                dx_next    = '0;
                dy_next    = '0;
                rsum_next  = '0;
            end
            MODE_RECT_CIRC, MODE_CIRC_RECT:
            begin
                flags_next = '{pre_hit: hit_x | hit_y, use_sq: 1'b1};
                dx_next    = kx_adj[DW-1:0];
                dy_next    = ky_adj[DW-1:0];
                rsum_next  = r[C-1:0];
            end
            MODE_CIRC_CIRC:
            begin
                flags_next = '{pre_hit: 1'b0, use_sq: 1'b1};
                dx_next    = DW'(acx - bcx);
                dy_next    = DW'(acy - bcy);
                rsum_next  = rs[C-1:0];
            end
            default:
            begin
                flags_next = '{pre_hit: 1'b0, use_sq: 1'b0};
                dx_next    = '0;
                dy_next    = '0;
                rsum_next  = '0;
            end
        endcase
    end

    // Advance when the stage is empty or its contents move on
    assign adv        = !valid_reg || out_ready;
    assign in_ready   = adv;
    assign valid_next = adv ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            rsum_reg  <= rsum_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign rsum      = rsum_reg;
    assign flags     = flags_reg;

endmodule

/* src/spot_square.sv */
// Middle stage: squares both offsets and the radius sum, one multiplier
// each. Depends on spot_pkg.
`timescale 1ns / 1ps

module spot_square
    import spot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS+2:0]  dx,
    input  logic signed [COORD_BITS+2:0]  dy,
    input  logic [COORD_BITS-1:0]         rsum,
    input  spot_flags_t                   flags_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*COORD_BITS+4:0]       dx2,
    output logic [2*COORD_BITS+4:0]       dy2,
    output logic [2*COORD_BITS-1:0]       rsum2,
    output spot_flags_t                   flags_out
);

    localparam int DW = COORD_BITS + 3;
    localparam int SQ = 2 * COORD_BITS + 5;
    localparam int RQ = 2 * COORD_BITS;

    logic signed [2*DW-1:0] px, py;
    logic [RQ-1:0]          pr;
    logic                   valid_reg, valid_next, adv;
    logic [SQ-1:0]          dx2_reg, dy2_reg;
    logic [RQ-1:0]          rsum2_reg;
    spot_flags_t            flags_reg;

    // Square the offsets and the radius sum
    always_comb
    begin
        px = dx * dx;
        py = dy * dy;
        pr = rsum * rsum;
    end

    assign adv        = !valid_reg || out_ready;
    assign in_ready   = adv;
    assign valid_next = adv ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            dx2_reg   <= px[SQ-1:0];
            dy2_reg   <= py[SQ-1:0];
            rsum2_reg <= pr;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign dx2       = dx2_reg;
    assign dy2       = dy2_reg;
    assign rsum2     = rsum2_reg;
    assign flags_out = flags_reg;

endmodule

/* src/spot_decide.sv */
// Result stage: adds the squares, compares with the squared radius sum and
// holds the verdict for the output channel. Depends on spot_pkg.
`timescale 1ns / 1ps

module spot_decide
    import spot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2*COORD_BITS+4:0] dx2,
    input  logic [2*COORD_BITS+4:0] dy2,
    input  logic [2*COORD_BITS-1:0] rsum2,
    input  spot_flags_t             flags,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    collide
);

    localparam int SQ = 2 * COORD_BITS + 5;
    localparam int RQ = 2 * COORD_BITS;

    logic [SQ:0] dist2, lim2;
    logic        valid_reg, valid_next, adv;
    logic        collide_reg, collide_next;

    // Strictly inside the radius sum counts as a hit
    always_comb
    begin
        dist2        = {1'b0, dx2} + {1'b0, dy2};
        lim2         = {{(SQ+1-RQ){1'b0}}, rsum2};
        collide_next = flags.pre_hit | (flags.use_sq & (dist2 < lim2));
    end

    assign adv        = !valid_reg || out_ready;
    assign in_ready   = adv;
    assign valid_next = adv ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            collide_reg <= collide_next;
    end

    assign out_valid = valid_reg;
    assign collide   = collide_reg;

endmodule

/* src/shape_pair_overlap_test.sv */
// Shape pair overlap test, top level: input register, prep, square and
// result stages. Depends on spot_pkg, spot_prep, spot_square, spot_decide.
// Each transaction is registered in turn in the input, prep, square and result stages.
// Throughput: one shape pair per cycle unless the output is stalled; each
// stage holds one pair and moves on whenever the stage below is free or draining.
// Reset: rst_n asynchronous, active low, empties all stages; no start-up.
`timescale 1ns / 1ps

module shape_pair_overlap_test
    import spot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // pos_a_x, pos_a_y, dim_a_x, dim_a_y, pos_b_x, pos_b_y, dim_b_x, dim_b_y, zero pad
    input  logic [8*COORD_BITS-1:0] s_tdata,
    // mode
    input  logic [MODE_BITS-1:0]    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // collide, zero pad
    output logic [OUT_BITS-1:0]     m_tdata
);

    localparam int C      = COORD_BITS;
    localparam int D      = COORD_BITS - 1;
    localparam int DW     = COORD_BITS + 3;
    localparam int SQ     = 2 * COORD_BITS + 5;
    localparam int RQ     = 2 * COORD_BITS;
    localparam int OFF_AY = C;
    localparam int OFF_AW = 2 * C;
    localparam int OFF_AH = 3 * C - 1;
    localparam int OFF_BX = 4 * C - 2;
    localparam int OFF_BY = 5 * C - 2;
    localparam int OFF_BW = 6 * C - 2;
    localparam int OFF_BH = 7 * C - 3;

    logic                 in_valid_reg, in_valid_next, in_adv;
    logic [MODE_BITS-1:0] mode_reg;
    logic signed [C-1:0]  pos_a_x_reg, pos_a_y_reg, pos_b_x_reg, pos_b_y_reg;
    logic [D-1:0]         dim_a_x_reg, dim_a_y_reg, dim_b_x_reg, dim_b_y_reg;

    logic                 prep_ready, prep_valid, sq_ready, sq_valid, dec_ready;
    logic signed [DW-1:0] dx, dy;
    logic [C-1:0]         rsum;
    spot_flags_t          prep_flags, sq_flags;
    logic [SQ-1:0]        dx2, dy2;
    logic [RQ-1:0]        rsum2;
    logic                 collide;

    // Input register: take a transaction whenever it is empty or moving on
    assign in_adv        = !in_valid_reg || prep_ready;
    assign s_tready      = in_adv;
    assign in_valid_next = in_adv ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
        begin
            mode_reg    <= s_tuser;
            pos_a_x_reg <= s_tdata[0 +: C];
            pos_a_y_reg <= s_tdata[OFF_AY +: C];
            dim_a_x_reg <= s_tdata[OFF_AW +: D];
            dim_a_y_reg <= s_tdata[OFF_AH +: D];
            pos_b_x_reg <= s_tdata[OFF_BX +: C];
            pos_b_y_reg <= s_tdata[OFF_BY +: C];
            dim_b_x_reg <= s_tdata[OFF_BW +: D];
            dim_b_y_reg <= s_tdata[OFF_BH +: D];
        end
    end

    spot_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (prep_ready),
        .mode      (mode_reg),
        .pos_a_x   (pos_a_x_reg),
        .pos_a_y   (pos_a_y_reg),
        .dim_a_x   (dim_a_x_reg),
        .dim_a_y   (dim_a_y_reg),
        .pos_b_x   (pos_b_x_reg),
        .pos_b_y   (pos_b_y_reg),
        .dim_b_x   (dim_b_x_reg),
        .dim_b_y   (dim_b_y_reg),
        .out_valid (prep_valid),
        .out_ready (sq_ready),
        .dx        (dx),
        .dy        (dy),
        .rsum      (rsum),
        .flags     (prep_flags)
    );

    spot_square #(.COORD_BITS(COORD_BITS)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (sq_ready),
        .dx        (dx),
        .dy        (dy),
        .rsum      (rsum),
        .flags_in  (prep_flags),
        .out_valid (sq_valid),
        .out_ready (dec_ready),
        .dx2       (dx2),
        .dy2       (dy2),
        .rsum2     (rsum2),
        .flags_out (sq_flags)
    );

    spot_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (dec_ready),
        .dx2       (dx2),
        .dy2       (dy2),
        .rsum2     (rsum2),
        .flags     (sq_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .collide   (collide)
    );

    // Pack the verdict into the lowest bit
    assign m_tdata = {{(OUT_BITS-1){1'b0}}, collide};

endmodule

/* src/spot_check.sv */
// Port-level checker for the shape pair overlap test, bound to the top level.
// Depends on spot_pkg and shape_pair_overlap_test_assert.svh.
`timescale 1ns / 1ps
`include "shape_pair_overlap_test_assert.svh"

module spot_check
    import spot_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    logic acc;

    assign acc = s_tvalid && s_tready;

    // A stalled result holds its verdict
    `SPOT_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input refuses only when every stage is full behind a stalled output
    `SPOT_ASSERT_IMP(a_full_stall, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // A draining output frees the whole pipeline for the next transaction
    `SPOT_ASSERT_IMP(a_drain_ready, clk, rst_n, m_tready, s_tready)

    // With no new transactions and a ready sink the pipeline empties
    `SPOT_ASSERT_IMP(a_drained, clk, rst_n, !$past(acc, 1) && !$past(acc, 2) && !$past(acc, 3) && !$past(acc, 4) && !$past(acc, 5) && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) && $past(m_tready, 4) && $past(m_tready, 5), !m_tvalid)

endmodule

bind shape_pair_overlap_test spot_check u_spot_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/shape_pair_overlap_test_test.sv */
// Testbench for shape_pair_overlap_test: directed table then random shape pairs,
// each result checked against its table expectation or a local overlap predictor. Depends on spot_pkg and
// the shape_pair_overlap_test RTL only.
`timescale 1ns / 1ps

module shape_pair_overlap_test_test;
    import spot_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int IDLE_MAX  = 3000;   // cycles with no transaction before giving up
    localparam int LONG_HOLD = 200;    // receiver back-pressure stretch
    localparam int DRAIN_TAIL = 8;     // extra wait after the last result

    // One shape pair as carried by s_tdata and s_tuser
    typedef struct packed {
        spot_mode_t     mode;
        logic [CW-1:0]  pos_a_x;
        logic [CW-1:0]  pos_a_y;
        logic [CW-2:0]  dim_a_x;
        logic [CW-2:0]  dim_a_y;
        logic [CW-1:0]  pos_b_x;
        logic [CW-1:0]  pos_b_y;
        logic [CW-2:0]  dim_b_x;
        logic [CW-2:0]  dim_b_y;
    } shape_pair_t;

    typedef enum logic [1:0] { WANT_MISS, WANT_HIT, WANT_PREDICT } want_t;

    typedef struct {
        shape_pair_t pair;
        want_t       want;
    } table_row_t;

    typedef struct {
        shape_pair_t pair;
        bit          collide;
    } due_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // pos_a_x, pos_a_y, dim_a_x, dim_a_y, pos_b_x, pos_b_y, dim_b_x, dim_b_y, zero pad
    logic [8*CW-1:0]     s_tdata;
    // mode
    logic [MODE_BITS-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // collide, zero pad
    logic [OUT_BITS-1:0] m_tdata;

    table_row_t directed_rows[$];
    due_t       collide_due[$];
    int         fault_count = 0;
    bit         tx_free_run = 0;
    bit         rx_free_run = 0;
    bit         rx_hold_req = 0;

    shape_pair_overlap_test #(.COORD_BITS(CW)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit box_overlap(longint ax, longint ay, longint aw, longint ah,
                                       longint bx, longint by, longint bw, longint bh);
        return (ax + aw > bx) && (ax < bx + bw) && (ay < by + bh) && (ay + ah > by);
    endfunction

    // Side test on one axis, all values doubled; o* describe the other axis
    function automatic bit side_reach(longint c, longint r, longint lo, longint sz,
                                      longint oc, longint olo, longint osz);
        longint d;
        bit     reach;
        d = lo + sz / 2 - c;
        if (d >= 0)
            reach = (c + r >= lo);
        else
            reach = !(c - r >= lo + sz);
        return reach && (oc <= olo + osz) && (oc >= olo);
    endfunction

    function automatic bit circle_box_hit(longint cx0, longint cy0, longint cw, longint ch,
                                          longint rx0, longint ry0, longint rw0, longint rh0);
        longint r, cx, cy, rx, ry, rw, rh, dx, dy;
        r  = (cw > ch) ? cw : ch;
        cx = 2 * cx0 + r;
        cy = 2 * cy0 + r;
        rx = 2 * rx0;
        ry = 2 * ry0;
        rw = 2 * rw0;
        rh = 2 * rh0;
        if (side_reach(cx, r, rx, rw, cy, ry, rh))
            return 1'b1;
        if (side_reach(cy, r, ry, rh, cx, rx, rw))
            return 1'b1;
        // Nearest corner, strictly inside the radius
        dx = rx + rw / 2 - cx;
        dy = ry + rh / 2 - cy;
        dx = (dx < 0) ? dx + rw / 2 : dx - rw / 2;
        dy = (dy < 0) ? dy + rh / 2 : dy - rh / 2;
        return dx * dx + dy * dy < r * r;
    endfunction

    function automatic bit circle_pair_hit(longint ax, longint ay, longint aw, longint ah,
                                           longint bx, longint by, longint bw, longint bh);
        longint ra, rb, dx, dy, s;
        ra = (aw > ah) ? aw : ah;
        rb = (bw > bh) ? bw : bh;
        dx = (2 * ax + ra) - (2 * bx + rb);
        dy = (2 * ay + ra) - (2 * by + rb);
        s  = ra + rb;
        return s * s > dx * dx + dy * dy;
    endfunction

    function automatic bit predict_collide(shape_pair_t p);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        ax = $signed(p.pos_a_x);
        ay = $signed(p.pos_a_y);
        aw = p.dim_a_x;
        ah = p.dim_a_y;
        bx = $signed(p.pos_b_x);
        by = $signed(p.pos_b_y);
        bw = p.dim_b_x;
        bh = p.dim_b_y;
        case (p.mode)
            MODE_RECT_RECT: return box_overlap(ax, ay, aw, ah, bx, by, bw, bh);
            MODE_RECT_CIRC: return circle_box_hit(bx, by, bw, bh, ax, ay, aw, ah);
            MODE_CIRC_RECT: return circle_box_hit(ax, ay, aw, ah, bx, by, bw, bh);
            default:        return circle_pair_hit(ax, ay, aw, ah, bx, by, bw, bh);
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic add_row(spot_mode_t m, int ax, int ay, int aw, int ah,
                           int bx, int by, int bw, int bh, want_t w);
        table_row_t row;
        row.pair.mode    = m;
        row.pair.pos_a_x = CW'(ax);
        row.pair.pos_a_y = CW'(ay);
        row.pair.dim_a_x = (CW-1)'(aw);
        row.pair.dim_a_y = (CW-1)'(ah);
        row.pair.pos_b_x = CW'(bx);
        row.pair.pos_b_y = CW'(by);
        row.pair.dim_b_x = (CW-1)'(bw);
        row.pair.dim_b_y = (CW-1)'(bh);
        row.want         = w;
        directed_rows    = {directed_rows, row};
    endtask

    function automatic logic [CW-1:0] pick_edge_pos();
        case ($urandom_range(0, 3))
            0:       return CW'(-(1 << (CW-1)));
            1:       return CW'((1 << (CW-1)) - 1);
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [CW-2:0] pick_edge_dim();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return (CW-1)'(1);
        endcase
    endfunction

    function automatic shape_pair_t make_random_pair();
        shape_pair_t p;
        int          span, reach, ax, ay;
        p.mode = spot_mode_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            // whole field range, covers every bit
            0, 1:
            begin
                p.pos_a_x = CW'($urandom);
                p.pos_a_y = CW'($urandom);
                p.dim_a_x = (CW-1)'($urandom);
                p.dim_a_y = (CW-1)'($urandom);
                p.pos_b_x = CW'($urandom);
                p.pos_b_y = CW'($urandom);
                p.dim_b_x = (CW-1)'($urandom);
                p.dim_b_y = (CW-1)'($urandom);
            end
            // corner values of every field
            2:
            begin
                p.pos_a_x = pick_edge_pos();
                p.pos_a_y = pick_edge_pos();
                p.dim_a_x = pick_edge_dim();
                p.dim_a_y = pick_edge_dim();
                p.pos_b_x = pick_edge_pos();
                p.pos_b_y = pick_edge_pos();
                p.dim_b_x = pick_edge_dim();
                p.dim_b_y = pick_edge_dim();
            end
            // neighbouring shapes, so that hits, touches and near misses are common
            default:
            begin
                span  = ($urandom_range(0, 7) == 0) ? 2000 : 12;
                reach = span + 4;
                ax = int'($urandom_range(0, 65535)) - 32768;
                ay = int'($urandom_range(0, 65535)) - 32768;
                p.pos_a_x = CW'(ax);
                p.pos_a_y = CW'(ay);
                p.dim_a_x = (CW-1)'($urandom_range(0, span));
                p.dim_a_y = (CW-1)'($urandom_range(0, span));
                p.pos_b_x = CW'(ax + int'($urandom_range(0, 2 * reach)) - reach);
                p.pos_b_y = CW'(ay + int'($urandom_range(0, 2 * reach)) - reach);
                p.dim_b_x = (CW-1)'($urandom_range(0, span));
                p.dim_b_y = (CW-1)'($urandom_range(0, span));
            end
        endcase
        return p;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drop valid and drive junk on data and mode for the whole gap
    task automatic idle_sender(int n);
        s_tvalid <= 1'b0;
        s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
        s_tuser  <= MODE_BITS'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // Offer one pair, hold until accepted, then log the expected answer
    task automatic send_pair(shape_pair_t p, bit collide);
        due_t d;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, p.dim_b_y, p.dim_b_x, p.pos_b_y, p.pos_b_x,
                     p.dim_a_y, p.dim_a_x, p.pos_a_y, p.pos_a_x};
        s_tuser  <= p.mode;
        do
            @(posedge clk);
        while (!s_tready);
        d.pair      = p;
        d.collide   = collide;
        collide_due = {collide_due, d};
    endtask

    task automatic send_with_gap(shape_pair_t p, bit collide);
        int gap;
        gap = tx_free_run ? 0 : pick_gap();
        if (gap > 0)
            idle_sender(gap);
        send_pair(p, collide);
    endtask

    task automatic run_random(int n);
        shape_pair_t p;
        for (int i = 0; i < n; i++)
        begin
            // reshuffle idling behaviour every block of pairs
            if (i % 64 == 0)
            begin
                tx_free_run = ($urandom_range(0, 3) == 0);
                rx_free_run = ($urandom_range(0, 3) == 0);
            end
            p = make_random_pair();
            send_with_gap(p, predict_collide(p));
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (collide_due.size() != 0);
    endtask

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        shape_pair_t p;
        bit          want_hit;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_RECT_RECT;

        // rectangle pairs: overlap, touching edges, zero size, extremes
        add_row(MODE_RECT_RECT, 0, 0, 10, 10, 5, 5, 10, 10, WANT_HIT);
        add_row(MODE_RECT_RECT, 0, 0, 10, 10, 10, 0, 10, 10, WANT_MISS);
        add_row(MODE_RECT_RECT, 0, 0, 10, 10, 0, 10, 10, 10, WANT_MISS);
        add_row(MODE_RECT_RECT, 0, 0, 0, 0, -5, -5, 10, 10, WANT_PREDICT);
        add_row(MODE_RECT_RECT, 0, 0, 0, 0, 0, 0, 10, 10, WANT_MISS);
        add_row(MODE_RECT_RECT, -32768, -32768, 32767, 32767,
                32767, 32767, 32767, 32767, WANT_MISS);
        add_row(MODE_RECT_RECT, -32768, -32768, 32767, 32767,
                -32768, -32768, 32767, 32767, WANT_HIT);
        add_row(MODE_RECT_RECT, -1, -1, 1, 1, -1, -1, 1, 1, WANT_HIT);
        // circle pairs: same centre, touching, two points, extremes
        add_row(MODE_CIRC_CIRC, 0, 0, 4, 4, 0, 0, 4, 4, WANT_HIT);
        add_row(MODE_CIRC_CIRC, 0, 0, 2, 2, 2, 0, 2, 2, WANT_MISS);
        add_row(MODE_CIRC_CIRC, 5, 5, 0, 0, 5, 5, 0, 0, WANT_MISS);
        add_row(MODE_CIRC_CIRC, -32768, -32768, 32767, 32767,
                32767, 32767, 32767, 32767, WANT_MISS);
        add_row(MODE_CIRC_CIRC, -32768, -32768, 32767, 32767,
                -32768, -32768, 32767, 32767, WANT_HIT);
        add_row(MODE_CIRC_CIRC, -32768, 32767, 0, 32767, 32767, -32768, 32767, 0,
                WANT_PREDICT);
        // circle against rectangle: inside, right, left and top side touching, corners, point, oblong, extremes
        add_row(MODE_CIRC_RECT, 0, 0, 4, 4, -10, -10, 100, 100, WANT_HIT);
        add_row(MODE_RECT_CIRC, -10, -10, 100, 100, 0, 0, 4, 4, WANT_HIT);
        add_row(MODE_CIRC_RECT, 0, 0, 2, 2, 2, 0, 5, 5, WANT_HIT);
        add_row(MODE_CIRC_RECT, 0, 0, 2, 2, -5, 0, 5, 5, WANT_PREDICT);
        add_row(MODE_CIRC_RECT, 0, 0, 2, 2, 0, 2, 5, 5, WANT_HIT);
        add_row(MODE_CIRC_RECT, 0, 0, 2, 2, 3, 3, 5, 5, WANT_MISS);
        add_row(MODE_CIRC_RECT, 0, 0, 4, 4, 3, 3, 5, 5, WANT_PREDICT);
        add_row(MODE_CIRC_RECT, 3, 3, 0, 0, 0, 0, 10, 10, WANT_PREDICT);
        add_row(MODE_CIRC_RECT, 0, 0, 8, 2, 9, 0, 4, 4, WANT_PREDICT);
        add_row(MODE_RECT_CIRC, -32768, -32768, 32767, 32767,
                32767, 32767, 32767, 32767, WANT_PREDICT);
        add_row(MODE_CIRC_RECT, -1, -1, 32767, 32767, -1, -1, 32767, 32767,
                WANT_PREDICT);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            p = directed_rows[i].pair;
            case (directed_rows[i].want)
                WANT_HIT:  want_hit = 1'b1;
                WANT_MISS: want_hit = 1'b0;
                default:   want_hit = predict_collide(p);
            endcase
            send_with_gap(p, want_hit);
        end

        // sender pause until the pipeline is empty
        wait_drained();
        run_random(500);

        // long receiver hold while the sender keeps offering back to back
        rx_hold_req = 1'b1;
        tx_free_run = 1'b1;
        repeat (40)
        begin
            p = make_random_pair();
            send_pair(p, predict_collide(p));
        end

        run_random(910);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- receiver and checker

    initial
    begin
        due_t d;
        int   hold_left;
        int   r;

        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            // check the result taken at this edge
            if (rst_n && m_tvalid && m_tready)
            begin
                if (collide_due.size() == 0)
                    report_fault($sformatf("unexpected result collide=%0d", m_tdata[0]));
                else
                begin
                    d = collide_due.pop_front();
                    if (m_tdata[0] !== d.collide)
                        report_fault($sformatf(
                            "%s A(%0d,%0d,%0d,%0d) B(%0d,%0d,%0d,%0d): want %0d got %0d",
                            d.pair.mode.name(),
                            $signed(d.pair.pos_a_x), $signed(d.pair.pos_a_y),
                            d.pair.dim_a_x, d.pair.dim_a_y,
                            $signed(d.pair.pos_b_x), $signed(d.pair.pos_b_y),
                            d.pair.dim_b_x, d.pair.dim_b_y,
                            d.collide, m_tdata[0]));
                end
            end

            // decide ready for the next cycle
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                m_tready   <= 1'b0;
            end
            else if (rx_free_run || !rst_n)
                m_tready <= rst_n;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready <= 1'b1;
                else
                begin
                    hold_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_MAX)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

/* shape_pair_overlap_test.f */
+incdir+src
src/spot_pkg.sv
src/spot_prep.sv
src/spot_square.sv
src/spot_decide.sv
src/shape_pair_overlap_test.sv
src/spot_check.sv
sim/shape_pair_overlap_test_test.sv
